/* src/utf8_codepoint_count_truncate_core_assert.svh */
// Assertion macros shared by the UTF-8 count and truncate core.
`ifndef UTF8_CODEPOINT_COUNT_TRUNCATE_CORE_ASSERT_SVH
`define UTF8_CODEPOINT_COUNT_TRUNCATE_CORE_ASSERT_SVH

`ifndef SYNTHESIS
`define UCCT_ASSERT_NEVER(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("ucct: forbidden condition seen");
`define UCCT_ASSERT_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ucct: implication violated");
`else
`define UCCT_ASSERT_NEVER(label, cond)
`define UCCT_ASSERT_IMPLIES(label, ante, cons)
`endif

`endif

/* src/ucct_pkg.sv */
// Types and constants of the UTF-8 count and truncate core.
package ucct_pkg;

  localparam int VALUE_W = 31;
  localparam int QUEUE_DEPTH = 4;

  localparam logic CFG_LIMIT_ENABLE = 1'b0;
  localparam logic CFG_MAX_CODE_POINTS = 1'b1;

  typedef enum logic [2:0] {
    BC_ASCII,
    BC_CONT,
    BC_LEAD2,
    BC_LEAD3,
    BC_LEAD4,
    BC_BAD
  } byte_class_t;

  typedef enum logic [2:0] {
    SBC_ANY,
    SBC_E0,
    SBC_ED,
    SBC_F0,
    SBC_F4
  } sbc_t;

  typedef struct packed {
    byte_class_t cls;
    sbc_t sbc;
    logic ge_a0;
    logic le_9f;
    logic ge_90;
    logic le_8f;
    logic has_byte;
    logic last;
  } beat_t;

  typedef struct packed {
    logic limit_enable;
    logic [VALUE_W-1:0] max_code_points;
  } cfg_t;

endpackage

/* src/utf8_codepoint_count_truncate_core.sv */
// Top level of the UTF-8 code point count and truncate core.
//
//  channel  direction  handshake            payload
//  in       sink       in_valid/in_stall    data_byte, has_byte, last_of_string
//  out      source     out_valid/out_stall  value, invalid_utf8
//  cfg      sink       cfg_we               cfg_index, cfg_data
//
// One byte per cycle while in_stall is low; each beat updates the decode state.
// A result appears in out_valid the cycle after the back end takes the last beat.
// A four-beat queue decouples input from decode; in_stall rises only when it is full.
// out_stall holds only last beats; other beats keep draining into the decode state.
// rst is synchronous and clears the queue, decode state, result valid and registers.
module utf8_codepoint_count_truncate_core #(
  parameter int COUNT_BITS = 31
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [7:0]                    data_byte,
  input  logic                          has_byte,
  input  logic                          last_of_string,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [ucct_pkg::VALUE_W-1:0]  value,
  output logic                          invalid_utf8,
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [ucct_pkg::VALUE_W-1:0]  cfg_data
);

  ucct_pkg::cfg_t  cfg;
  ucct_pkg::beat_t push_beat;
  ucct_pkg::beat_t head;
  logic            push;
  logic            pop;
  logic            empty;
  logic            full;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ucct_pkg::CFG_LIMIT_ENABLE:    cfg.limit_enable    <= cfg_data[0];
        ucct_pkg::CFG_MAX_CODE_POINTS: cfg.max_code_points <= cfg_data;
        default: ;
      endcase
    end
  end

  ucct_front u_front (
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .data_byte      (data_byte),
    .has_byte       (has_byte),
    .last_of_string (last_of_string),
    .full           (full),
    .push           (push),
    .beat           (push_beat)
  );

  ucct_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_beat (push_beat),
    .pop       (pop),
    .head      (head),
    .empty     (empty),
    .full      (full)
  );

  ucct_back #(
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .empty        (empty),
    .beat         (head),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .value        (value),
    .invalid_utf8 (invalid_utf8)
  );

endmodule

/* src/ucct_fifo.sv */
// Short queue of classified beats between front and back.
`include "utf8_codepoint_count_truncate_core_assert.svh"

module ucct_fifo (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  ucct_pkg::beat_t push_beat,
  input  logic            pop,
  output ucct_pkg::beat_t head,
  output logic            empty,
  output logic            full
);

  localparam int DEPTH = ucct_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  ucct_pkg::beat_t mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign empty = (count == '0);
  assign full  = (count == CNT_W'(DEPTH));
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_beat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  `UCCT_ASSERT_NEVER(a_no_push_full, push && full && !pop)
  `UCCT_ASSERT_NEVER(a_no_pop_empty, pop && empty)
  `UCCT_ASSERT_IMPLIES(a_count_bound, 1'b1, count <= CNT_W'(DEPTH))

endmodule

/* src/ucct_front.sv */
// Front end: accept input beats, classify each byte, push into the queue.
module ucct_front (
  input  logic            in_valid,
  output logic            in_stall,
  input  logic [7:0]      data_byte,
  input  logic            has_byte,
  input  logic            last_of_string,
  input  logic            full,
  output logic            push,
  output ucct_pkg::beat_t beat
);

  assign in_stall = full;
  assign push     = in_valid && !full;

  always_comb begin
    beat          = '0;
    beat.has_byte = has_byte;
    beat.last     = last_of_string;
    beat.ge_a0    = (data_byte >= 8'hA0);
    beat.le_9f    = (data_byte <= 8'h9F);
    beat.ge_90    = (data_byte >= 8'h90);
    beat.le_8f    = (data_byte <= 8'h8F);
    beat.sbc      = ucct_pkg::SBC_ANY;
    priority if (data_byte < 8'h80) begin
      beat.cls = ucct_pkg::BC_ASCII;
    end else if (data_byte <= 8'hBF) begin
      beat.cls = ucct_pkg::BC_CONT;
    end else if (data_byte >= 8'hC2 && data_byte <= 8'hDF) begin
      beat.cls = ucct_pkg::BC_LEAD2;
    end else if (data_byte >= 8'hE0 && data_byte <= 8'hEF) begin
      beat.cls = ucct_pkg::BC_LEAD3;
    end else if (data_byte >= 8'hF0 && data_byte <= 8'hF4) begin
      beat.cls = ucct_pkg::BC_LEAD4;
    end else begin
      beat.cls = ucct_pkg::BC_BAD;
    end
    if (data_byte == 8'hE0) beat.sbc = ucct_pkg::SBC_E0;
    if (data_byte == 8'hED) beat.sbc = ucct_pkg::SBC_ED;
    if (data_byte == 8'hF0) beat.sbc = ucct_pkg::SBC_F0;
    if (data_byte == 8'hF4) beat.sbc = ucct_pkg::SBC_F4;
  end

endmodule

/* src/ucct_back.sv */
// Back end: decode state, code point count, limit check and result register.
`include "utf8_codepoint_count_truncate_core_assert.svh"

module ucct_back #(
  parameter int COUNT_BITS = 31
) (
  input  logic                          clk,
  input  logic                          rst,
  input  ucct_pkg::cfg_t                cfg,
  input  logic                          empty,
  input  ucct_pkg::beat_t               beat,
  output logic                          pop,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [ucct_pkg::VALUE_W-1:0]  value,
  output logic                          invalid_utf8
);

  localparam int VW = ucct_pkg::VALUE_W;

  logic [COUNT_BITS-1:0] byte_offset, byte_offset_next;
  logic [COUNT_BITS-1:0] cp_count, cp_count_next;
  logic [COUNT_BITS-1:0] seq_start, seq_start_next;
  logic [COUNT_BITS-1:0] trunc_offset, trunc_offset_next;
  logic [1:0]            cont_left, cont_left_next;
  ucct_pkg::sbc_t        sbc, sbc_next;
  logic                  truncated, truncated_next;
  logic                  error, error_next;
  logic                  done;
  logic                  cont_ok;
  logic                  bad;
  logic [VW-1:0]         result;

  assign pop = !empty && (!beat.last || !out_valid || !out_stall);

  always_comb begin
    cont_ok = 1'b0;
    if (beat.cls == ucct_pkg::BC_CONT) begin
      unique case (sbc)
        ucct_pkg::SBC_E0: cont_ok = beat.ge_a0;
        ucct_pkg::SBC_ED: cont_ok = beat.le_9f;
        ucct_pkg::SBC_F0: cont_ok = beat.ge_90;
        ucct_pkg::SBC_F4: cont_ok = beat.le_8f;
        default:          cont_ok = 1'b1;
      endcase
    end
  end

  always_comb begin
    byte_offset_next  = byte_offset;
    cp_count_next     = cp_count;
    seq_start_next    = seq_start;
    trunc_offset_next = trunc_offset;
    cont_left_next    = cont_left;
    sbc_next          = sbc;
    truncated_next    = truncated;
    error_next        = error;
    done              = 1'b0;
    if (beat.has_byte) begin
      byte_offset_next = (byte_offset != '1) ? byte_offset + 1'b1 : byte_offset;
      if (!truncated && !error) begin
        if (cont_left == 2'd0) begin
          seq_start_next = byte_offset;
          sbc_next       = ucct_pkg::SBC_ANY;
          unique case (beat.cls)
            ucct_pkg::BC_ASCII: done = 1'b1;
            ucct_pkg::BC_LEAD2: cont_left_next = 2'd1;
            ucct_pkg::BC_LEAD3: begin
              cont_left_next = 2'd2;
              sbc_next       = beat.sbc;
            end
            ucct_pkg::BC_LEAD4: begin
              cont_left_next = 2'd3;
              sbc_next       = beat.sbc;
            end
            default: error_next = 1'b1;
          endcase
        end else if (!cont_ok) begin
          error_next     = 1'b1;
          cont_left_next = 2'd0;
          sbc_next       = ucct_pkg::SBC_ANY;
        end else begin
          sbc_next       = ucct_pkg::SBC_ANY;
          cont_left_next = cont_left - 2'd1;
          done           = (cont_left == 2'd1);
        end
      end
    end
    if (done) begin
      cp_count_next = (cp_count != '1) ? cp_count + 1'b1 : cp_count;
      if (cfg.limit_enable && (VW'(cp_count_next) > cfg.max_code_points)) begin
        truncated_next    = 1'b1;
        trunc_offset_next = seq_start_next;
      end
    end
  end

  always_comb begin
    bad = error_next || (cont_left_next != 2'd0 && !truncated_next);
    if (bad) begin
      result = '0;
    end else if (cfg.limit_enable) begin
      result = truncated_next ? VW'(trunc_offset_next) : VW'(byte_offset_next);
    end else begin
      result = VW'(cp_count_next);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_offset  <= '0;
      cp_count     <= '0;
      seq_start    <= '0;
      trunc_offset <= '0;
      cont_left    <= '0;
      sbc          <= ucct_pkg::SBC_ANY;
      truncated    <= 1'b0;
      error        <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (pop && beat.last) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (pop) begin
        if (beat.last) begin
          byte_offset  <= '0;
          cp_count     <= '0;
          seq_start    <= '0;
          trunc_offset <= '0;
          cont_left    <= '0;
          sbc          <= ucct_pkg::SBC_ANY;
          truncated    <= 1'b0;
          error        <= 1'b0;
        end else begin
          byte_offset  <= byte_offset_next;
          cp_count     <= cp_count_next;
          seq_start    <= seq_start_next;
          trunc_offset <= trunc_offset_next;
          cont_left    <= cont_left_next;
          sbc          <= sbc_next;
          truncated    <= truncated_next;
          error        <= error_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && beat.last) begin
      value        <= result;
      invalid_utf8 <= bad;
    end
  end

  `UCCT_ASSERT_NEVER(a_trunc_err_excl, truncated && error)
  `UCCT_ASSERT_IMPLIES(a_err_idle_seq, error, cont_left == 2'd0)
  `UCCT_ASSERT_IMPLIES(a_trunc_idle_seq, truncated, cont_left == 2'd0)
  `UCCT_ASSERT_IMPLIES(a_sbc_only_mid, cont_left == 2'd0, sbc == ucct_pkg::SBC_ANY)

endmodule

/* tb/testbench.sv */
// Scoreboarded testbench for the UTF-8 code point count and truncate core.
module testbench;

  class utf8_scoreboard;
    typedef struct packed {
      logic [ucct_pkg::VALUE_W-1:0] value;
      logic                         invalid;
    } result_t;

    bit                         limit_en;
    bit [ucct_pkg::VALUE_W-1:0] max_cp;
    bit [ucct_pkg::VALUE_W-1:0] offset;
    bit [ucct_pkg::VALUE_W-1:0] cp_count;
    bit [ucct_pkg::VALUE_W-1:0] seq_start;
    bit [ucct_pkg::VALUE_W-1:0] trunc_at;
    bit [1:0]                   cont_left;
    ucct_pkg::sbc_t             sbc;
    bit                         truncated;
    bit                         bad;
    result_t                    expected_q[$];
    int                         failures;
    int                         reported;

    function void set_cfg(logic idx, logic [ucct_pkg::VALUE_W-1:0] data);
      if (idx == ucct_pkg::CFG_LIMIT_ENABLE) limit_en = data[0];
      else max_cp = data;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void clear_string();
      offset = '0;
      cp_count = '0;
      seq_start = '0;
      trunc_at = '0;
      cont_left = '0;
      sbc = ucct_pkg::SBC_ANY;
      truncated = 1'b0;
      bad = 1'b0;
    endfunction

    function bit [ucct_pkg::VALUE_W-1:0] sat_inc(bit [ucct_pkg::VALUE_W-1:0] v);
      return (v == '1) ? v : v + 1'b1;
    endfunction

    function void finish_code_point();
      cp_count = sat_inc(cp_count);
      if (limit_en && cp_count > max_cp) begin
        truncated = 1'b1;
        trunc_at = seq_start;
      end
    endfunction

    function void take_byte(bit [7:0] b);
      bit [ucct_pkg::VALUE_W-1:0] here;
      bit [7:0]                   lo;
      bit [7:0]                   hi;
      here = offset;
      offset = sat_inc(offset);
      if (truncated || bad) return;
      if (cont_left == 0) begin
        seq_start = here;
        sbc = ucct_pkg::SBC_ANY;
        if (b < 8'h80) begin
          finish_code_point();
        end else if (b >= 8'hC2 && b <= 8'hDF) begin
          cont_left = 2'd1;
        end else if (b >= 8'hE0 && b <= 8'hEF) begin
          cont_left = 2'd2;
          if (b == 8'hE0) sbc = ucct_pkg::SBC_E0;
          else if (b == 8'hED) sbc = ucct_pkg::SBC_ED;
        end else if (b >= 8'hF0 && b <= 8'hF4) begin
          cont_left = 2'd3;
          if (b == 8'hF0) sbc = ucct_pkg::SBC_F0;
          else if (b == 8'hF4) sbc = ucct_pkg::SBC_F4;
        end else begin
          bad = 1'b1;
        end
        return;
      end
      lo = 8'h80;
      hi = 8'hBF;
      case (sbc)
        ucct_pkg::SBC_E0: lo = 8'hA0;
        ucct_pkg::SBC_ED: hi = 8'h9F;
        ucct_pkg::SBC_F0: lo = 8'h90;
        ucct_pkg::SBC_F4: hi = 8'h8F;
        default: ;
      endcase
      if (b < lo || b > hi) begin
        bad = 1'b1;
        cont_left = '0;
        sbc = ucct_pkg::SBC_ANY;
        return;
      end
      sbc = ucct_pkg::SBC_ANY;
      cont_left--;
      if (cont_left == 0) finish_code_point();
    endfunction

    function void note_beat(logic [7:0] b, logic h, logic l);
      result_t r;
      if (h) take_byte(b);
      if (!l) return;
      if (bad || (cont_left != 0 && !truncated)) begin
        r.value = '0;
        r.invalid = 1'b1;
      end else if (limit_en) begin
        r.value = truncated ? trunc_at : offset;
        r.invalid = 1'b0;
      end else begin
        r.value = cp_count;
        r.invalid = 1'b0;
      end
      expected_q.push_back(r);
      clear_string();
    endfunction

    function void check_result(logic [ucct_pkg::VALUE_W-1:0] v, logic inv);
      result_t r;
      if (expected_q.size() == 0) begin
        failures++;
        if (reported < 10) begin
          reported++;
          $display("ucct: unexpected result value %0d invalid %0b", v, inv);
        end
        return;
      end
      r = expected_q.pop_front();
      if (v !== r.value || inv !== r.invalid) begin
        failures++;
        if (reported < 10) begin
          reported++;
          $display("ucct: mismatch value exp %0d got %0d, invalid exp %0b got %0b",
                   r.value, v, r.invalid, inv);
        end
      end
    endfunction
  endclass

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         in_valid;
  logic                         in_stall;
  logic [7:0]                   data_byte;
  logic                         has_byte;
  logic                         last_of_string;
  logic                         out_valid;
  logic                         out_stall;
  logic [ucct_pkg::VALUE_W-1:0] value;
  logic                         invalid_utf8;
  logic                         cfg_we;
  logic                         cfg_index;
  logic [ucct_pkg::VALUE_W-1:0] cfg_data;

  utf8_scoreboard sb;
  logic [7:0]     str_q[$];
  int             items;

  utf8_codepoint_count_truncate_core i_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .data_byte      (data_byte),
    .has_byte       (has_byte),
    .last_of_string (last_of_string),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .value          (value),
    .invalid_utf8   (invalid_utf8),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  initial forever #5 clk = ~clk;

  initial begin
    #2000000;
    $display("testbench: done, errors");
    $finish;
  end

  task automatic send_item(input logic [7:0] b, input logic h, input logic l,
                           input bit burst);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    data_byte <= b;
    has_byte <= h;
    last_of_string <= l;
    do @(posedge clk); while (in_stall !== 1'b0);
    sb.note_beat(b, h, l);
  endtask

  task automatic send_string(input bit plain);
    bit burst;
    bit sep;
    int n;
    burst = ($urandom_range(0, 3) == 0);
    sep = !plain && ($urandom_range(0, 5) == 0);
    n = str_q.size();
    if (n == 0) begin
      send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1, burst);
      items++;
      return;
    end
    for (int i = 0; i < n; i++) begin
      if (!plain && $urandom_range(0, 15) == 0)
        send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0, burst);
      send_item(str_q[i], 1'b1, (i == n - 1) && !sep, burst);
      items++;
    end
    if (sep) begin
      send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1, burst);
      items++;
    end
  endtask

  task automatic push_code_point();
    int       kind;
    bit [7:0] lead;
    bit [7:0] lo;
    bit [7:0] hi;
    kind = $urandom_range(0, 3);
    lo = 8'h80;
    hi = 8'hBF;
    case (kind)
      0: str_q.push_back(8'($urandom_range(0, 127)));
      1: begin
        str_q.push_back(8'($urandom_range(8'hC2, 8'hDF)));
        str_q.push_back(8'($urandom_range(8'h80, 8'hBF)));
      end
      2: begin
        lead = 8'($urandom_range(8'hE0, 8'hEF));
        if (lead == 8'hE0) lo = 8'hA0;
        if (lead == 8'hED) hi = 8'h9F;
        str_q.push_back(lead);
        str_q.push_back(8'($urandom_range(lo, hi)));
        str_q.push_back(8'($urandom_range(8'h80, 8'hBF)));
      end
      default: begin
        lead = 8'($urandom_range(8'hF0, 8'hF4));
        if (lead == 8'hF0) lo = 8'h90;
        if (lead == 8'hF4) hi = 8'h8F;
        str_q.push_back(lead);
        str_q.push_back(8'($urandom_range(lo, hi)));
        str_q.push_back(8'($urandom_range(8'h80, 8'hBF)));
        str_q.push_back(8'($urandom_range(8'h80, 8'hBF)));
      end
    endcase
  endtask

  task automatic build_string();
    int       chars;
    int       mode;
    bit [7:0] b;
    str_q.delete();
    chars = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 10);
    for (int i = 0; i < chars; i++) begin
      if (i == chars / 2 && $urandom_range(0, 9) == 0) begin
        case ($urandom_range(0, 3))
          0: begin
            str_q.push_back(8'hE0);
            str_q.push_back(8'($urandom_range(8'h80, 8'h9F)));
          end
          1: begin
            str_q.push_back(8'hED);
            str_q.push_back(8'($urandom_range(8'hA0, 8'hBF)));
          end
          2: begin
            str_q.push_back(8'hF0);
            str_q.push_back(8'($urandom_range(8'h80, 8'h8F)));
          end
          default: begin
            str_q.push_back(8'hF4);
            str_q.push_back(8'($urandom_range(8'h90, 8'hBF)));
          end
        endcase
      end
      push_code_point();
    end
    if ($urandom_range(0, 4) != 0 || str_q.size() == 0) return;
    mode = $urandom_range(0, 2);
    case (mode)
      0: str_q[$urandom_range(0, str_q.size() - 1)] = 8'($urandom_range(0, 255));
      1: str_q.pop_back();
      default: begin
        case ($urandom_range(0, 3))
          0: b = 8'($urandom_range(8'h80, 8'hBF));
          1: b = 8'($urandom_range(8'hC0, 8'hC1));
          2: b = 8'($urandom_range(8'hF5, 8'hFF));
          default: b = 8'($urandom_range(0, 255));
        endcase
        str_q.insert($urandom_range(0, str_q.size()), b);
      end
    endcase
  endtask

  task automatic write_cfg(input logic idx, input logic [ucct_pkg::VALUE_W-1:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    sb.set_cfg(idx, data);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  initial begin : result_sink
    int gap;
    int seen;
    bit long_done;
    out_stall = 1'b0;
    seen = 0;
    long_done = 1'b0;
    wait (rst === 1'b0);
    forever begin
      if (!long_done && seen == 20) begin
        gap = 400;
        long_done = 1'b1;
      end else if ((seen / 25) % 3 == 2) begin
        gap = 0;
      end else begin
        gap = $urandom_range(0, 7);
      end
      if (gap > 0) begin
        @(negedge clk);
        out_stall <= 1'b1;
        repeat (gap - 1) @(negedge clk);
        @(negedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (out_valid !== 1'b1);
      sb.check_result(value, invalid_utf8);
      seen++;
    end
  end

  initial begin : stimulus
    logic                         le;
    logic [ucct_pkg::VALUE_W-1:0] mx;
    sb = new;
    in_valid = 1'b0;
    data_byte = '0;
    has_byte = 1'b0;
    last_of_string = 1'b0;
    cfg_we = 1'b0;
    cfg_index = ucct_pkg::CFG_LIMIT_ENABLE;
    cfg_data = '0;
    items = 0;
    repeat (6) @(negedge clk);
    rst <= 1'b0;

    str_q.delete();
    send_string(1'b1);
    str_q = '{8'h00, 8'h7F, 8'hC2, 8'h80, 8'hF4, 8'h8F, 8'hBF, 8'hBF};
    send_string(1'b1);
    str_q = '{8'hE0, 8'h9F};
    send_string(1'b1);
    str_q = '{8'hF0, 8'h8F};
    send_string(1'b1);
    send_item(8'hFF, 1'b0, 1'b0, 1'b0);
    str_q = '{8'hC1};
    send_string(1'b1);
    str_q = '{8'hF5};
    send_string(1'b1);
    str_q = '{8'hE1, 8'h80};
    send_string(1'b1);

    wait_idle();
    write_cfg(ucct_pkg::CFG_LIMIT_ENABLE, 31'd1);
    write_cfg(ucct_pkg::CFG_MAX_CODE_POINTS, 31'd0);
    str_q = '{8'h41, 8'hFF};
    send_string(1'b1);
    str_q = '{8'hC2, 8'h41};
    send_string(1'b1);

    wait_idle();
    write_cfg(ucct_pkg::CFG_MAX_CODE_POINTS, 31'd1);
    str_q = '{8'h41, 8'hE0, 8'h41};
    send_string(1'b1);

    for (int p = 0; p < 6; p++) begin
      wait_idle();
      case (p)
        0: begin le = 1'b0; mx = '1; end
        1: begin le = 1'b1; mx = '0; end
        2: begin le = 1'b1; mx = '1; end
        3: begin le = 1'b1; mx = ucct_pkg::VALUE_W'($urandom_range(1, 6)); end
        4: begin le = 1'b0; mx = ucct_pkg::VALUE_W'($urandom()); end
        default: begin le = 1'b1; mx = ucct_pkg::VALUE_W'($urandom_range(0, 12)); end
      endcase
      write_cfg(ucct_pkg::CFG_LIMIT_ENABLE, ucct_pkg::VALUE_W'(le));
      write_cfg(ucct_pkg::CFG_MAX_CODE_POINTS, mx);
      items = 0;
      while (items < 250) begin
        build_string();
        send_string(1'b0);
      end
    end

    wait_idle();
    repeat (10) @(posedge clk);
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
